// ===== sv/md5_message_digest_defines.svh =====
// Assertion macros shared by the MD5 checker.
`ifndef MD5_MESSAGE_DIGEST_DEFINES_SVH
`define MD5_MESSAGE_DIGEST_DEFINES_SVH
// Implication checked at every rising clock edge outside reset.
`define MD5_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);
// Implication whose consequence is checked in the cycle after the antecedent.
`define MD5_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);
`endif

// ===== sv/md5_pkg.sv =====
// Shared types, constants and round tables for the MD5 digest block.
`timescale 1ns / 1ps
package md5_pkg;
  localparam logic [31:0] INIT_A = 32'h67452301;
  localparam logic [31:0] INIT_B = 32'hefcdab89;
  localparam logic [31:0] INIT_C = 32'h98badcfe;
  localparam logic [31:0] INIT_D = 32'h10325476;
  localparam logic [7:0]  PAD_BYTE = 8'h80;
  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned QUEUE_AW = 2;

  // Item as it travels from the front part to the back part.
  typedef struct packed {
    logic [7:0] msg_byte;
    logic       byte_present;
    logic       end_of_message;
  } md5_item_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PAD,
    ST_ROUND,
    ST_ADD,
    ST_EMIT
  } md5_state_t;

  function automatic logic [31:0] round_const(input logic [5:0] i);
    logic [31:0] k;
    unique case (i)
      6'd0: k = 32'hd76aa478; 6'd1: k = 32'he8c7b756; 6'd2: k = 32'h242070db;
      6'd3: k = 32'hc1bdceee; 6'd4: k = 32'hf57c0faf; 6'd5: k = 32'h4787c62a;
      6'd6: k = 32'ha8304613; 6'd7: k = 32'hfd469501; 6'd8: k = 32'h698098d8;
      6'd9: k = 32'h8b44f7af; 6'd10: k = 32'hffff5bb1; 6'd11: k = 32'h895cd7be;
      6'd12: k = 32'h6b901122; 6'd13: k = 32'hfd987193; 6'd14: k = 32'ha679438e;
      6'd15: k = 32'h49b40821; 6'd16: k = 32'hf61e2562; 6'd17: k = 32'hc040b340;
      6'd18: k = 32'h265e5a51; 6'd19: k = 32'he9b6c7aa; 6'd20: k = 32'hd62f105d;
      6'd21: k = 32'h02441453; 6'd22: k = 32'hd8a1e681; 6'd23: k = 32'he7d3fbc8;
      6'd24: k = 32'h21e1cde6; 6'd25: k = 32'hc33707d6; 6'd26: k = 32'hf4d50d87;
      6'd27: k = 32'h455a14ed; 6'd28: k = 32'ha9e3e905; 6'd29: k = 32'hfcefa3f8;
      6'd30: k = 32'h676f02d9; 6'd31: k = 32'h8d2a4c8a; 6'd32: k = 32'hfffa3942;
      6'd33: k = 32'h8771f681; 6'd34: k = 32'h6d9d6122; 6'd35: k = 32'hfde5380c;
      6'd36: k = 32'ha4beea44; 6'd37: k = 32'h4bdecfa9; 6'd38: k = 32'hf6bb4b60;
      6'd39: k = 32'hbebfbc70; 6'd40: k = 32'h289b7ec6; 6'd41: k = 32'heaa127fa;
      6'd42: k = 32'hd4ef3085; 6'd43: k = 32'h04881d05; 6'd44: k = 32'hd9d4d039;
      6'd45: k = 32'he6db99e5; 6'd46: k = 32'h1fa27cf8; 6'd47: k = 32'hc4ac5665;
      6'd48: k = 32'hf4292244; 6'd49: k = 32'h432aff97; 6'd50: k = 32'hab9423a7;
      6'd51: k = 32'hfc93a039; 6'd52: k = 32'h655b59c3; 6'd53: k = 32'h8f0ccc92;
      6'd54: k = 32'hffeff47d; 6'd55: k = 32'h85845dd1; 6'd56: k = 32'h6fa87e4f;
      6'd57: k = 32'hfe2ce6e0; 6'd58: k = 32'ha3014314; 6'd59: k = 32'h4e0811a1;
      6'd60: k = 32'hf7537e82; 6'd61: k = 32'hbd3af235; 6'd62: k = 32'h2ad7d2bb;
      default: k = 32'heb86d391;
    endcase
    return k;
  endfunction

  function automatic logic [4:0] rot_amount(input logic [5:0] i);
    logic [4:0] s;
    unique case ({i[5:4], i[1:0]})
      4'd0: s = 5'd7;   4'd1: s = 5'd12;  4'd2: s = 5'd17;  4'd3: s = 5'd22;
      4'd4: s = 5'd5;   4'd5: s = 5'd9;   4'd6: s = 5'd14;  4'd7: s = 5'd20;
      4'd8: s = 5'd4;   4'd9: s = 5'd11;  4'd10: s = 5'd16; 4'd11: s = 5'd23;
      4'd12: s = 5'd6;  4'd13: s = 5'd10; 4'd14: s = 5'd15; default: s = 5'd21;
    endcase
    return s;
  endfunction

  // Message word used by round i; products are cut to 4 bits, i.e. mod 16.
  function automatic logic [3:0] word_index(input logic [5:0] i);
    logic [3:0] g;
    unique case (i[5:4])
      2'd0: g = i[3:0];
      2'd1: g = 4'(5 * i[3:0] + 1);
      2'd2: g = 4'(3 * i[3:0] + 5);
      default: g = 4'(7 * i[3:0]);
    endcase
    return g;
  endfunction
endpackage

// ===== sv/md5_message_digest.sv =====
// MD5 message digest, one message byte per input item.
//
// Input channel (in_valid/in_ready): msg_byte, byte_present, end_of_message.
// Bytes pack little-endian into 64-byte blocks. Each full block is compressed
// by one round unit, followed by the chaining add.
// An item with end_of_message pads the message (0x80, zeros, 64-bit bit
// length) in a byte walk, compresses one or two final
// blocks and puts the digest on the output channel (out_valid/out_ready):
// digest_low = {h1, h0}, digest_high = {h3, h2}.
// Byte items are taken while the engine is idle; each 64th byte starts a
// block compression that holds the engine, so sustained throughput is set
// by the single round unit.
// Items with neither byte nor end mark are taken and dropped.
// A four-entry queue separates input from the engine, so input is taken
// while the engine compresses or a digest waits for out_ready, up to its depth.
// The engine holds in ST_EMIT only while an earlier digest is not yet taken.
// Reset: synchronous, loads the MD5 initial values and clears the count.
`timescale 1ns / 1ps
module md5_message_digest (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  msg_byte,
  input  logic        byte_present,
  input  logic        end_of_message,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [63:0] digest_low,
  output logic [63:0] digest_high
);
  import md5_pkg::*;

  logic      q_push, q_full, q_pop, q_empty;
  md5_item_t q_item, q_head;

  md5_front u_front (
    .rst, .in_valid, .in_ready, .msg_byte, .byte_present,
    .end_of_message, .q_push, .q_item, .q_full
  );

  md5_queue u_queue (
    .clk, .rst, .push(q_push), .push_item(q_item), .full(q_full),
    .pop(q_pop), .head_item(q_head), .empty(q_empty)
  );

  md5_engine u_engine (
    .clk, .rst, .q_empty, .q_head, .q_pop, .out_valid, .out_ready,
    .digest_low, .digest_high
  );
endmodule

// ===== sv/md5_queue.sv =====
// Small FIFO between the input front end and the compression engine.
`timescale 1ns / 1ps
module md5_queue (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  md5_pkg::md5_item_t push_item,
  output logic             full,
  input  logic             pop,
  output md5_pkg::md5_item_t head_item,
  output logic             empty
);
  import md5_pkg::*;

  md5_item_t       slots [QUEUE_DEPTH];
  logic [QUEUE_AW-1:0] wr_ptr;
  logic [QUEUE_AW-1:0] rd_ptr;
  logic [QUEUE_AW:0]   fill;

  assign full      = (fill == (QUEUE_AW+1)'(QUEUE_DEPTH));
  assign empty     = (fill == '0);
  assign head_item = slots[rd_ptr];

  // Pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push && !full) wr_ptr <= wr_ptr + 1'b1;
      if (pop && !empty) rd_ptr <= rd_ptr + 1'b1;
      fill <= fill + (QUEUE_AW+1)'(push && !full) - (QUEUE_AW+1)'(pop && !empty);
    end
  end

  // Storage
  always_ff @(posedge clk) begin
    if (push && !full) slots[wr_ptr] <= push_item;
  end
endmodule

// ===== sv/md5_front.sv =====
// Input front end: takes items, drops idle ones, queues the rest.
`timescale 1ns / 1ps
module md5_front (
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [7:0]         msg_byte,
  input  logic               byte_present,
  input  logic               end_of_message,
  output logic               q_push,
  output md5_pkg::md5_item_t q_item,
  input  logic               q_full
);
  import md5_pkg::*;

  logic work_item;

  // Items with neither a byte nor an end mark change nothing
  assign work_item = byte_present || end_of_message;
  assign in_ready  = !rst && !q_full;
  assign q_push    = in_valid && in_ready && work_item;
  assign q_item    = '{msg_byte: msg_byte, byte_present: byte_present,
                       end_of_message: end_of_message};
endmodule

// ===== sv/md5_engine.sv =====
// Back end: block assembly, padding, 64-round compression and digest output.
`timescale 1ns / 1ps
module md5_engine (
  input  logic               clk,
  input  logic               rst,
  input  logic               q_empty,
  input  md5_pkg::md5_item_t q_head,
  output logic               q_pop,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [63:0]        digest_low,
  output logic [63:0]        digest_high
);
  import md5_pkg::*;

  md5_state_t  state, state_next;
  logic [31:0] blk [16];
  logic [31:0] h0, h1, h2, h3;
  logic [31:0] a, b, c, d;
  logic [5:0]  round_index;
  logic [60:0] byte_count;
  logic [5:0]  pad_pos;
  logic        final_block;   // padding with length is in the block
  logic        finishing;     // compressing for an end mark
  logic        out_full;

  logic [5:0]  pos;
  logic        take_byte;
  logic        block_done;
  logic [31:0] f_val, sum, rot, new_b;
  logic [4:0]  sh;
  logic [63:0] bit_len;

  // Padding walk: pad_first marks the byte holding 0x80; length fits if start < 56
  logic pad_first;
  logic pad_len_fits;
  logic pad_pos_start_ok;

  assign pos      = byte_count[5:0];
  assign bit_len  = {byte_count, 3'b000};
  assign out_valid = out_full;
  assign pad_pos_start_ok = pad_len_fits;

  // Round function of the current round
  always_comb begin
    unique case (round_index[5:4])
      2'd0: f_val = (b & c) | (~b & d);
      2'd1: f_val = (d & b) | (~d & c);
      2'd2: f_val = b ^ c ^ d;
      default: f_val = c ^ (b | ~d);
    endcase
    sum   = a + f_val + round_const(round_index) + blk[word_index(round_index)];
    sh    = rot_amount(round_index);
    rot   = (sum << sh) | (sum >> (6'd32 - {1'b0, sh}));
    new_b = b + rot;
  end

  // Handshake with the queue: one item taken in idle state
  assign take_byte  = (state == ST_IDLE) && !q_empty;
  assign q_pop      = take_byte;
  assign block_done = q_head.byte_present && (pos == 6'd63);

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (take_byte) begin
          if (block_done) state_next = ST_ROUND;
          else if (q_head.end_of_message) state_next = ST_PAD;
        end
      end
      ST_PAD:   if (pad_pos == 6'd63) state_next = ST_ROUND;
      ST_ROUND: if (round_index == 6'd63) state_next = ST_ADD;
      ST_ADD: begin
        if (!finishing) state_next = ST_IDLE;
        else if (final_block) state_next = ST_EMIT;
        else state_next = ST_PAD;
      end
      ST_EMIT:  if (!out_full) state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      round_index <= '0;
      byte_count  <= '0;
      finishing   <= 1'b0;
      final_block <= 1'b0;
      out_full    <= 1'b0;
      h0 <= INIT_A; h1 <= INIT_B; h2 <= INIT_C; h3 <= INIT_D;
    end else begin
      state <= state_next;
      if (out_full && out_ready) out_full <= 1'b0;
      unique case (state)
        ST_IDLE: begin
          if (take_byte) begin
            if (q_head.byte_present) byte_count <= byte_count + 61'd1;
            finishing <= q_head.end_of_message;
            final_block <= 1'b0;
          end
        end
        ST_PAD: begin
          if (pad_pos == 6'd63) final_block <= (pad_pos_start_ok);
        end
        ST_ROUND: round_index <= round_index + 6'd1;
        ST_ADD: begin
          h0 <= h0 + a; h1 <= h1 + b; h2 <= h2 + c; h3 <= h3 + d;
        end
        ST_EMIT: begin
          if (!out_full) begin
            out_full    <= 1'b1;
            digest_low  <= {h1, h0};
            digest_high <= {h3, h2};
            h0 <= INIT_A; h1 <= INIT_B; h2 <= INIT_C; h3 <= INIT_D;
            byte_count <= '0;
            finishing  <= 1'b0;
          end
        end
        default: ;
      endcase
    end
  end

  // Padding walk position; pad_first survives a data-only compression so a
  // message ending on a block boundary gets its 0x80 at the next block start
  always_ff @(posedge clk) begin
    if (rst) begin
      pad_first    <= 1'b0;
      pad_len_fits <= 1'b0;
      pad_pos      <= '0;
    end else if (take_byte && q_head.end_of_message) begin
      pad_pos      <= q_head.byte_present ? pos + 6'd1 : pos;
      pad_first    <= 1'b1;
      pad_len_fits <= (q_head.byte_present ? pos + 6'd1 : pos) < 6'd56
                      && !(q_head.byte_present && pos == 6'd63);
    end else if (state == ST_ADD && finishing && !final_block) begin
      // Last padding block: zeros plus length (0x80 first if pad_first is set)
      pad_pos      <= '0;
      pad_len_fits <= 1'b1;
    end else if (state == ST_PAD && pad_pos != 6'd63) begin
      pad_pos   <= pad_pos + 6'd1;
      pad_first <= 1'b0;
    end else if (state == ST_PAD) begin
      pad_first <= 1'b0;
    end
  end

  // Block words and working variables
  always_ff @(posedge clk) begin
    if (take_byte && q_head.byte_present)
      blk[pos[5:2]][8*pos[1:0] +: 8] <= q_head.msg_byte;
    if (state == ST_PAD) begin
      if (pad_len_fits && pad_pos[5:3] == 3'd7)
        blk[pad_pos[5:2]][8*pad_pos[1:0] +: 8] <=
          bit_len[8*pad_pos[2:0] +: 8];
      else
        blk[pad_pos[5:2]][8*pad_pos[1:0] +: 8] <= pad_first ? PAD_BYTE : 8'h00;
    end
    if (state_next == ST_ROUND && state != ST_ROUND) begin
      a <= h0; b <= h1; c <= h2; d <= h3;
    end else if (state == ST_ROUND) begin
      a <= d; b <= new_b; c <= b; d <= c;
    end
  end
endmodule

// ===== sv/md5_checker.sv =====
// Port-level checks for the MD5 digest block, bound to the top level.
`timescale 1ns / 1ps
`include "md5_message_digest_defines.svh"
module md5_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_ready,
  input logic        end_of_message,
  input logic        out_valid,
  input logic        out_ready,
  input logic [63:0] digest_low,
  input logic [63:0] digest_high
);
  `MD5_ASSERT_NEXT(a_out_hold, clk, rst, out_valid && !out_ready, out_valid,
    "digest dropped before taken")
  `MD5_ASSERT_NEXT(a_out_stable, clk, rst, out_valid && !out_ready,
    $stable(digest_low) && $stable(digest_high), "digest changed while stalled")
  `MD5_ASSERT_NEXT(a_one_shot, clk, rst, out_valid && out_ready, !out_valid,
    "digest repeated on the next cycle")
  `MD5_ASSERT_NEXT(a_no_early, clk, rst, in_valid && in_ready && end_of_message,
    !out_valid || $past(out_valid), "digest appeared right after end item")
endmodule

bind md5_message_digest md5_checker u_md5_checker (
  .clk, .rst, .in_valid, .in_ready, .end_of_message, .out_valid, .out_ready,
  .digest_low, .digest_high
);

// ===== test/tb_top.sv =====
// Self-checking testbench for the streaming MD5 digest block.
`timescale 1ns / 1ps
module tb_top;
  import md5_pkg::*;

  // Golden MD5 engine plus the queue of digests it predicts.
  class digest_board;
    logic [31:0] chain [4];
    logic [31:0] words [16];
    logic [60:0] nbytes;
    logic [127:0] pending [$];
    int errors;
    int checked;

    function new();
      errors = 0;
      checked = 0;
      restart();
    endfunction

    function void restart();
      chain[0] = INIT_A;
      chain[1] = INIT_B;
      chain[2] = INIT_C;
      chain[3] = INIT_D;
      nbytes = '0;
    endfunction

    function void put(int pos, logic [7:0] v);
      words[pos / 4][(pos % 4) * 8 +: 8] = v;
    endfunction

    function void compress();
      logic [31:0] a, b, c, d, f, sum, nb;
      logic [31:0] ks [64];
      int s [16];
      int g;
      ks = '{32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee,
             32'hf57c0faf, 32'h4787c62a, 32'ha8304613, 32'hfd469501,
             32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
             32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821,
             32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
             32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
             32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed,
             32'ha9e3e905, 32'hfcefa3f8, 32'h676f02d9, 32'h8d2a4c8a,
             32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
             32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
             32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05,
             32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
             32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039,
             32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d, 32'h85845dd1,
             32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
             32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391};
      s = '{7, 12, 17, 22, 5, 9, 14, 20, 4, 11, 16, 23, 6, 10, 15, 21};
      a = chain[0];
      b = chain[1];
      c = chain[2];
      d = chain[3];
      for (int i = 0; i < 64; i++) begin
        if (i < 16) begin
          f = (b & c) | (~b & d);
          g = i;
        end else if (i < 32) begin
          f = (d & b) | (~d & c);
          g = (5 * i + 1) % 16;
        end else if (i < 48) begin
          f = b ^ c ^ d;
          g = (3 * i + 5) % 16;
        end else begin
          f = c ^ (b | ~d);
          g = (7 * i) % 16;
        end
        sum = a + f + ks[i] + words[g];
        nb = b + ((sum << s[(i / 16) * 4 + i % 4]) | (sum >> (32 - s[(i / 16) * 4 + i % 4])));
        a = d;
        d = c;
        c = b;
        b = nb;
      end
      chain[0] += a;
      chain[1] += b;
      chain[2] += c;
      chain[3] += d;
    endfunction

    // Called for every accepted input item.
    function void note_item(logic [7:0] mb, logic bp, logic eom);
      int pos;
      logic [63:0] bits;
      if (bp) begin
        pos = nbytes[5:0];
        put(pos, mb);
        nbytes++;
        if (pos == 63) compress();
      end
      if (!eom) return;
      pos = nbytes[5:0];
      put(pos, PAD_BYTE);
      for (int p = pos + 1; p < 64; p++) put(p, 8'h00);
      if (pos >= 56) begin
        compress();
        for (int w = 0; w < 16; w++) words[w] = '0;
      end
      bits = {nbytes, 3'b000};
      words[14] = bits[31:0];
      words[15] = bits[63:32];
      compress();
      pending.push_back({chain[3], chain[2], chain[1], chain[0]});
      restart();
    endfunction

    function void report(string what);
      errors++;
      $display("digest error: %s", what);
    endfunction

    function void check_digest(logic [63:0] lo, logic [63:0] hi);
      logic [127:0] want;
      checked++;
      if (pending.size() == 0) begin
        report($sformatf("unexpected digest %h_%h", hi, lo));
        return;
      end
      want = pending.pop_front();
      if (lo !== want[63:0])
        report($sformatf("digest_low %h, want %h", lo, want[63:0]));
      if (hi !== want[127:64])
        report($sformatf("digest_high %h, want %h", hi, want[127:64]));
    endfunction
  endclass

  logic clk = 0;
  logic rst = 1;
  logic in_valid = 0;
  logic in_ready;
  logic [7:0] msg_byte = 0;
  logic byte_present = 0;
  logic end_of_message = 0;
  logic out_valid;
  logic out_ready = 0;
  logic [63:0] digest_low, digest_high;

  digest_board board = new();
  longint cycles = 0;
  int sent = 0;
  bit quiet = 0;
  bit hold_sink = 0;

  md5_message_digest dut (.*);

  always #1 clk = ~clk;

  // Watchdog.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > 2000000) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // Check digests at the accepting edge.
  always @(posedge clk)
    if (!rst && out_valid && out_ready) board.check_digest(digest_low, digest_high);

  // Result-side stalls in bursts; a long hold when asked.
  initial begin
    int n;
    @(negedge rst);
    forever begin
      @(posedge clk);
      if (hold_sink) begin
        out_ready <= 0;
        for (int i = 0; i < 900; i++) @(posedge clk);
        hold_sink = 0;
        out_ready <= 1;
      end else if (!quiet && $urandom_range(0, 5) == 0) begin
        n = $urandom_range(1, 12);
        out_ready <= 0;
        repeat (n) @(posedge clk);
        out_ready <= 1;
      end else begin
        out_ready <= 1;
      end
    end
  end

  // Offer one item and hold it until taken, with random gaps beforehand.
  task automatic send_item(logic [7:0] mb, logic bp, logic eom);
    if (!quiet && $urandom_range(0, 7) == 0) begin
      in_valid <= 0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
    in_valid <= 1;
    msg_byte <= mb;
    byte_present <= bp;
    end_of_message <= eom;
    do @(posedge clk); while (!in_ready);
    board.note_item(mb, bp, eom);
    sent++;
  endtask

  task automatic send_message(int len);
    for (int i = 0; i < len; i++) begin
      // noise: idle items that change nothing
      if ($urandom_range(0, 30) == 0) send_item(8'($urandom), 1'b0, 1'b0);
      send_item(8'($urandom), 1'b1, i == len - 1);
    end
    if (len == 0) send_item(8'($urandom), 1'b0, 1'b1);
  endtask

  task automatic wait_drained();
    in_valid <= 0;
    do @(posedge clk); while (board.pending.size() != 0);
  endtask

  initial begin
    int lens [8];
    int len;
    repeat (5) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // Directed: empty message, idle items, byte extremes, padding boundaries.
    send_item(8'h00, 1'b0, 1'b1);
    send_item(8'hff, 1'b0, 1'b0);
    send_item(8'hff, 1'b1, 1'b1);
    send_item(8'h00, 1'b1, 1'b0);
    send_item(8'h55, 1'b0, 1'b0);
    send_item(8'haa, 1'b1, 1'b1);
    lens = '{55, 56, 63, 64, 65, 119, 120, 2};
    for (int k = 0; k < 8; k++) send_message(lens[k]);
    // sender pauses until every digest is in
    wait_drained();

    // Back pressure: several short messages while the sink holds off.
    hold_sink = 1;
    for (int k = 0; k < 8; k++) send_message($urandom_range(0, 3));
    wait_drained();

    // Random messages, mostly short, a few spanning several blocks.
    while (sent < 1600) begin
      if (sent > 1300) quiet = 1;
      len = ($urandom_range(0, 9) == 0) ? $urandom_range(64, 200) : $urandom_range(0, 70);
      send_message(len);
    end
    in_valid <= 0;
    do @(posedge clk); while (board.pending.size() != 0);
    repeat (300) @(posedge clk);

    $display("Sent %0d items; checked %0d digests incl. empty, padding-boundary and",
             sent, board.checked);
    $display("multi-block messages, with stalls on both sides.");
    if (board.errors == 0 && board.pending.size() == 0)
      $display("SCOREBOARD CLEAN");
    else
      $display("SCOREBOARD MISMATCH");
    $finish;
  end
endmodule

// ===== md5_message_digest.f =====
+incdir+sv
sv/md5_pkg.sv
sv/md5_queue.sv
sv/md5_front.sv
sv/md5_engine.sv
sv/md5_message_digest.sv
sv/md5_checker.sv
test/tb_top.sv
